@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the chain code encoder modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcc assertion failed");

// Next-cycle implication, disabled during reset.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcc assertion failed");

`endif

@@ rtl/core/bcc_pkg.sv @@
// Types, codes and helper functions of the chain code encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    localparam int FIELD_COORD_W = 16;
    localparam int OUT_PERIM_W   = 27;
    localparam int LEN_W         = 11;

    typedef enum logic [1:0] {
        ST_MOVE   = 2'd0,
        ST_CLOSE  = 2'd1,
        ST_SINGLE = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_CUT   = 1'b1
    } op_kind_t;

    // one request handed from the front to the back
    typedef struct packed {
        op_kind_t                 kind;
        logic                     last;
        logic [FIELD_COORD_W-1:0] x;
        logic [FIELD_COORD_W-1:0] y;
    } op_t;

    // relation of a coordinate to the previous one
    localparam logic [1:0] REL_LESS = 2'd0;
    localparam logic [1:0] REL_EQ   = 2'd1;
    localparam logic [1:0] REL_MORE = 2'd2;

    localparam logic [3:0] MV_SAME = 4'd0;
    localparam logic [3:0] MV_E    = 4'd1;
    localparam logic [3:0] MV_NE   = 4'd2;
    localparam logic [3:0] MV_N    = 4'd3;
    localparam logic [3:0] MV_NW   = 4'd4;
    localparam logic [3:0] MV_W    = 4'd5;
    localparam logic [3:0] MV_SW   = 4'd6;
    localparam logic [3:0] MV_S    = 4'd7;
    localparam logic [3:0] MV_SE   = 4'd8;

    localparam logic [LEN_W-1:0] LEN_AXIS = 11'd1000;
    localparam logic [LEN_W-1:0] LEN_DIAG = 11'd1414;

    // y grows downward, so a smaller y is north
    function automatic logic [3:0] code_of(input logic [1:0] rx, input logic [1:0] ry);
        logic [3:0] c;
        c = MV_SAME;
        case (rx)
            REL_LESS:
            begin
                case (ry)
                    REL_LESS: c = MV_NW;
                    REL_EQ:   c = MV_W;
                    default:  c = MV_SW;
                endcase
            end
            REL_EQ:
            begin
                case (ry)
                    REL_LESS: c = MV_N;
                    REL_EQ:   c = MV_SAME;
                    default:  c = MV_S;
                endcase
            end
            default:
            begin
                case (ry)
                    REL_LESS: c = MV_NE;
                    REL_EQ:   c = MV_E;
                    default:  c = MV_SE;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] move_len(input logic [3:0] code);
        logic [LEN_W-1:0] len;
        if (code == MV_SAME)
            len = '0;
        else if (code[0])
            len = LEN_AXIS;
        else
            len = LEN_DIAG;
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bcc_front.sv @@
// Front end: accepts boundary points, drops points after a cut, emits requests.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcc_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bcc_pkg::FIELD_COORD_W-1:0] x_coord,
    input  wire logic [bcc_pkg::FIELD_COORD_W-1:0] y_coord,
    input  wire logic                              outer_contour,
    input  wire logic                              final_point,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output bcc_pkg::op_t                           q_op
);

    logic skipping_reg, skipping_next;
    logic accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && !skipping_reg;

    always_comb
    begin
        q_op.kind = outer_contour ? bcc_pkg::OP_POINT : bcc_pkg::OP_CUT;
        q_op.last = final_point;
        q_op.x    = x_coord;
        q_op.y    = y_coord;
    end

    // a non-final cut discards everything up to and including the next final point
    always_comb
    begin
        skipping_next = skipping_reg;
        if (accept)
        begin
            if (skipping_reg)
                skipping_next = !final_point;
            else if (!outer_contour && !final_point)
                skipping_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skipping_reg <= 1'b0;
        else
            skipping_reg <= skipping_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/bcc_queue.sv @@
// Small register queue of requests between front and back.
// Depends on bcc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire bcc_pkg::op_t push_op,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output bcc_pkg::op_t      head_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcc_pkg::op_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_op;
    end

    `BCC_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, count_reg != '0)
    `BCC_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, count_reg != CNT_W'(DEPTH))
    `BCC_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ rtl/core/bcc_back.sv @@
// Back end: holds chain state, encodes moves, sums perimeter, drives results.
// Depends on bcc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcc_back #(
    parameter int COORD_BITS = 16,
    parameter int PERIM_BITS = 27
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            op_valid,
    input  wire bcc_pkg::op_t                    op,
    output logic                                 op_pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [3:0]                           move_code,
    output logic [1:0]                           status,
    output logic [bcc_pkg::OUT_PERIM_W-1:0]      perimeter_milli,
    output logic                                 chain_end
);

    localparam int FW = bcc_pkg::FIELD_COORD_W;
    localparam int OW = bcc_pkg::OUT_PERIM_W;
    localparam int LW = bcc_pkg::LEN_W;

    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic [PERIM_BITS-1:0] perim_reg, perim_next;
    logic have_start_reg, have_start_next;
    logic have_moves_reg, have_moves_next;
    logic close_pending_reg, close_pending_next;

    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            out_move_reg, out_move_next;
    bcc_pkg::status_t      out_status_reg, out_status_next;
    logic [PERIM_BITS-1:0] out_perim_reg, out_perim_next;
    logic                  out_end_reg, out_end_next;

    logic [COORD_BITS+FW-1:0]  x_ext, y_ext;
    logic [COORD_BITS-1:0]     op_x, op_y;
    logic [3:0]                step_code, close_code;
    logic [PERIM_BITS:0]       sum_wide;
    logic [PERIM_BITS-1:0]     sum_sat;
    logic [PERIM_BITS+OW-1:0]  perim_out_ext;
    logic                      load_ok;

    function automatic logic [1:0] rel(input logic [COORD_BITS-1:0] from,
                                       input logic [COORD_BITS-1:0] to);
        logic [1:0] r;
        if (to < from)
            r = bcc_pkg::REL_LESS;
        else if (to == from)
            r = bcc_pkg::REL_EQ;
        else
            r = bcc_pkg::REL_MORE;
        return r;
    endfunction

    // only the low COORD_BITS bits of a coordinate take part
    assign x_ext = {{COORD_BITS{1'b0}}, op.x};
    assign y_ext = {{COORD_BITS{1'b0}}, op.y};
    assign op_x  = x_ext[COORD_BITS-1:0];
    assign op_y  = y_ext[COORD_BITS-1:0];

    assign step_code  = bcc_pkg::code_of(rel(prev_x_reg, op_x), rel(prev_y_reg, op_y));
    assign close_code = bcc_pkg::code_of(rel(prev_x_reg, start_x_reg),
                                         rel(prev_y_reg, start_y_reg));

    assign sum_wide = {1'b0, perim_reg}
                    + {{(PERIM_BITS + 1 - LW){1'b0}}, bcc_pkg::move_len(step_code)};
    assign sum_sat  = sum_wide[PERIM_BITS] ? {PERIM_BITS{1'b1}} : sum_wide[PERIM_BITS-1:0];

    assign load_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        prev_x_next        = prev_x_reg;
        prev_y_next        = prev_y_reg;
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        perim_next         = perim_reg;
        have_start_next    = have_start_reg;
        have_moves_next    = have_moves_reg;
        close_pending_next = close_pending_reg;
        out_valid_next     = out_valid_reg;
        out_move_next      = out_move_reg;
        out_status_next    = out_status_reg;
        out_perim_next     = out_perim_reg;
        out_end_next       = out_end_reg;
        op_pop             = 1'b0;

        if (load_ok)
            out_valid_next = 1'b0;

        if (close_pending_reg)
        begin
            // second result of a final point: the move back to the start
            if (load_ok)
            begin
                out_valid_next     = 1'b1;
                out_move_next      = close_code;
                out_status_next    = bcc_pkg::ST_CLOSE;
                out_perim_next     = perim_reg;
                out_end_next       = 1'b1;
                have_start_next    = 1'b0;
                have_moves_next    = 1'b0;
                perim_next         = '0;
                close_pending_next = 1'b0;
            end
        end
        else if (op_valid && load_ok)
        begin
            op_pop = 1'b1;
            case (op.kind)
                bcc_pkg::OP_CUT:
                begin
                    out_valid_next = 1'b1;
                    out_end_next   = 1'b1;
                    out_move_next  = bcc_pkg::MV_SAME;
                    out_perim_next = '0;
                    if (!have_start_reg)
                        out_status_next = bcc_pkg::ST_EMPTY;
                    else if (!have_moves_reg)
                        out_status_next = bcc_pkg::ST_SINGLE;
                    else
                    begin
                        out_status_next = bcc_pkg::ST_CLOSE;
                        out_move_next   = close_code;
                        out_perim_next  = perim_reg;
                    end
                    have_start_next = 1'b0;
                    have_moves_next = 1'b0;
                    perim_next      = '0;
                end
                default:
                begin
                    if (!have_start_reg)
                    begin
                        start_x_next    = op_x;
                        start_y_next    = op_y;
                        prev_x_next     = op_x;
                        prev_y_next     = op_y;
                        perim_next      = '0;
                        have_moves_next = 1'b0;
                        have_start_next = !op.last;
                        if (op.last)
                        begin
                            out_valid_next  = 1'b1;
                            out_move_next   = bcc_pkg::MV_SAME;
                            out_status_next = bcc_pkg::ST_SINGLE;
                            out_perim_next  = '0;
                            out_end_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        prev_x_next        = op_x;
                        prev_y_next        = op_y;
                        perim_next         = sum_sat;
                        have_moves_next    = 1'b1;
                        close_pending_next = op.last;
                        out_valid_next     = 1'b1;
                        out_move_next      = step_code;
                        out_status_next    = bcc_pkg::ST_MOVE;
                        out_perim_next     = sum_sat;
                        out_end_next       = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_start_reg    <= 1'b0;
            have_moves_reg    <= 1'b0;
            close_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            perim_reg         <= '0;
        end
        else
        begin
            have_start_reg    <= have_start_next;
            have_moves_reg    <= have_moves_next;
            close_pending_reg <= close_pending_next;
            out_valid_reg     <= out_valid_next;
            perim_reg         <= perim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_x_reg     <= prev_x_next;
        prev_y_reg     <= prev_y_next;
        start_x_reg    <= start_x_next;
        start_y_reg    <= start_y_next;
        out_move_reg   <= out_move_next;
        out_status_reg <= out_status_next;
        out_perim_reg  <= out_perim_next;
        out_end_reg    <= out_end_next;
    end

    assign perim_out_ext   = {{OW{1'b0}}, out_perim_reg};
    assign out_valid       = out_valid_reg;
    assign move_code       = out_move_reg;
    assign status          = out_status_reg;
    assign perimeter_milli = perim_out_ext[OW-1:0];
    assign chain_end       = out_end_reg;

    `BCC_ASSERT_IMPL(a_close_has_moves, clk, rst_n, close_pending_reg,
                     have_start_reg && have_moves_reg)
    `BCC_ASSERT_IMPL(a_no_pop_while_closing, clk, rst_n, close_pending_reg, !op_pop)
    `BCC_ASSERT_NEXT(a_final_move_then_close, clk, rst_n,
                     out_valid_reg && !out_stall && out_status_reg == bcc_pkg::ST_MOVE
                     && close_pending_reg,
                     out_valid_reg && out_status_reg == bcc_pkg::ST_CLOSE && out_end_reg)

endmodule

`default_nettype wire

@@ rtl/core/boundary_chain_code_encoder.sv @@
// Path: a point waits in a queue slot; its first result is registered in the back end.
// Throughput: one point per cycle while the queue is not full. A final point after a move
// gives two results; no pop until the second enters the single output register.
// Reset: asynchronous, active low; chain state and queue empty, no clearing pass.
// Top level of the 8-connected chain code encoder; depends on bcc_pkg,
// bcc_front, bcc_queue and bcc_back.
`timescale 1ns / 1ps
`default_nettype none

module boundary_chain_code_encoder #(
    parameter int COORD_BITS  = 16,
    parameter int PERIM_BITS  = 27,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // point channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] x_coord,
    input  wire logic [15:0] y_coord,
    input  wire logic        outer_contour,
    input  wire logic        final_point,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       move_code,
    output logic [1:0]       status,
    output logic [26:0]      perimeter_milli,
    output logic             chain_end
);

    // Front: drops points after a cut and turns every point it keeps into a
    // request (point or cut). Its only stall source is a full queue.
    logic         q_push;
    logic         q_full;
    bcc_pkg::op_t q_push_op;

    // Back: pops one request per cycle while its output register is free and no close waits.
    logic         q_pop;
    logic         q_head_valid;
    bcc_pkg::op_t q_head_op;

    bcc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .outer_contour (outer_contour),
        .final_point   (final_point),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_op          (q_push_op)
    );

    // Short queue so a stalled result sink does not immediately stall points.
    bcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    // Chain state, direction coding, saturating perimeter, closing move.
    bcc_back #(
        .COORD_BITS (COORD_BITS),
        .PERIM_BITS (PERIM_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .op_valid        (q_head_valid),
        .op              (q_head_op),
        .op_pop          (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .move_code       (move_code),
        .status          (status),
        .perimeter_milli (perimeter_milli),
        .chain_end       (chain_end)
    );

endmodule

`default_nettype wire
